// ===== rtl/rmq_pkg.sv =====
// Shared types and codes for the range mode query core.
// No dependencies; imported by range_mode_query_core.
package rmq_pkg;

	localparam logic [1:0] OP_CLEAR  = 2'd0;
	localparam logic [1:0] OP_APPEND = 2'd1;
	localparam logic [1:0] OP_QUERY  = 2'd2;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_CNT_RD,
		ST_CNT_VAL,
		ST_CNT_UPD,
		ST_CLR_RD,
		ST_CLR_WR,
		ST_FINISH
	} rmq_state_t;

endpackage

// ===== rtl/range_mode_query_core.sv =====
// Range mode query core: element memory, frequency memory and a small sequencer.
// Depends on rmq_pkg for opcodes and the sequencer state type.

// Clear and append transfers are handled in the idle state. A query walks its range twice
// over the frequency memory: each counting step reads the element, reads its frequency,
// then increments it and writes it back, and each clearing step reads the element and
// writes its frequency back to zero; a query that fails its range check goes straight to
// its result. After reset the frequency memory is swept to zero, one entry a cycle, and
// no input transfer is taken during the sweep. A query result is held in an output
// register, so new input transfers are taken while it waits.
module range_mode_query_core #(
	parameter int DEPTH       = 65536,
	parameter int VALUE_WIDTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  opcode,
	input  logic [15:0] value,
	input  logic [15:0] left_index,
	input  logic [15:0] right_index,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] mode_value,
	output logic [16:0] mode_count,
	output logic        error
);
	import rmq_pkg::*;

	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int SPAN  = 2 ** VALUE_WIDTH;

	rmq_state_t state_q, state_d;

	logic [VALUE_WIDTH-1:0] elem_mem [DEPTH];
	logic [CNT_W-1:0]       freq_mem [SPAN];

	logic [VALUE_WIDTH-1:0] elem_rd_q;
	logic [CNT_W-1:0]       freq_rd_q;
	logic [CNT_W-1:0]       count_q;
	logic [IDX_W-1:0]       idx_q;
	logic [IDX_W-1:0]       hi_q;
	logic [IDX_W-1:0]       lo_q;
	logic [VALUE_WIDTH-1:0] sweep_q;
	logic [VALUE_WIDTH-1:0] best_val_q;
	logic [CNT_W-1:0]       best_cnt_q;
	logic                   err_q;
	logic                   out_valid_q;
	logic [15:0]            res_value_q;
	logic [16:0]            res_count_q;
	logic                   res_error_q;

	logic                   accept;
	logic                   is_append;
	logic                   is_query;
	logic [31:0]            left_ext;
	logic [31:0]            right_ext;
	logic [31:0]            lo_ext;
	logic [31:0]            hi_ext;
	logic                   range_bad;
	logic [31:0]            value_ext;
	logic [CNT_W-1:0]       cnt_inc;
	logic                   take_best;
	logic                   out_load;
	logic                   freq_we;
	logic [VALUE_WIDTH-1:0] freq_wa;
	logic [CNT_W-1:0]       freq_wd;
	logic [31:0]            best_val_ext;
	logic [31:0]            best_cnt_ext;

	assign accept    = in_valid && in_ready;
	assign is_append = (opcode == OP_APPEND) && (32'(count_q) < 32'(DEPTH));
	assign is_query  = (opcode == OP_QUERY);
	assign left_ext  = 32'(left_index);
	assign right_ext = 32'(right_index);
	assign lo_ext    = (left_ext > right_ext) ? right_ext : left_ext;
	assign hi_ext    = (left_ext > right_ext) ? left_ext : right_ext;
	assign range_bad = (count_q == '0) || (hi_ext >= 32'(count_q));
	assign value_ext = 32'(value);
	assign cnt_inc   = freq_rd_q + CNT_W'(1);
	assign take_best = (cnt_inc > best_cnt_q) ||
		((cnt_inc == best_cnt_q) && (elem_rd_q < best_val_q));
	assign out_load  = (state_q == ST_FINISH) && (!out_valid_q || out_ready);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_INIT: begin
				if (sweep_q == {VALUE_WIDTH{1'b1}}) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (accept && is_query) state_d = range_bad ? ST_FINISH : ST_CNT_RD;
			end
			ST_CNT_RD:  state_d = ST_CNT_VAL;
			ST_CNT_VAL: state_d = ST_CNT_UPD;
			ST_CNT_UPD: state_d = (idx_q == hi_q) ? ST_CLR_RD : ST_CNT_RD;
			ST_CLR_RD:  state_d = ST_CLR_WR;
			ST_CLR_WR:  state_d = (idx_q == hi_q) ? ST_FINISH : ST_CLR_RD;
			ST_FINISH: begin
				if (out_load) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		freq_we  = 1'b0;
		freq_wa  = elem_rd_q;
		freq_wd  = '0;
		unique case (state_q)
			ST_INIT: begin
				freq_we = 1'b1;
				freq_wa = sweep_q;
			end
			ST_IDLE: in_ready = 1'b1;
			ST_CNT_UPD: begin
				freq_we = 1'b1;
				freq_wd = cnt_inc;
			end
			ST_CLR_WR: freq_we = 1'b1;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept && is_append) elem_mem[count_q[IDX_W-1:0]] <= value_ext[VALUE_WIDTH-1:0];
		elem_rd_q <= elem_mem[idx_q];
	end

	always_ff @(posedge clk) begin
		if (freq_we) freq_mem[freq_wa] <= freq_wd;
		freq_rd_q <= freq_mem[elem_rd_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			count_q     <= '0;
			sweep_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_INIT) sweep_q <= sweep_q + VALUE_WIDTH'(1);
			if (accept && (opcode == OP_CLEAR)) begin
				count_q <= '0;
			end else if (accept && is_append) begin
				count_q <= count_q + CNT_W'(1);
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && is_query) begin
			idx_q      <= lo_ext[IDX_W-1:0];
			hi_q       <= hi_ext[IDX_W-1:0];
			best_val_q <= '0;
			best_cnt_q <= '0;
			err_q      <= range_bad;
		end
		if (state_q == ST_CNT_UPD) begin
			if (take_best) begin
				best_val_q <= elem_rd_q;
				best_cnt_q <= cnt_inc;
			end
			if (idx_q == hi_q) begin
				idx_q <= lo_q;
			end else begin
				idx_q <= idx_q + IDX_W'(1);
			end
		end
		if (state_q == ST_CLR_WR && idx_q != hi_q) idx_q <= idx_q + IDX_W'(1);
		if (out_load) begin
			res_value_q <= best_val_ext[15:0];
			res_count_q <= best_cnt_ext[16:0];
			res_error_q <= err_q;
		end
	end

	// The clearing pass restarts from the low end of the range.
	always_ff @(posedge clk) begin
		if (accept && is_query) lo_q <= lo_ext[IDX_W-1:0];
	end

	assign best_val_ext = 32'(best_val_q);
	assign best_cnt_ext = 32'(best_cnt_q);

	assign out_valid  = out_valid_q;
	assign mode_value = res_value_q;
	assign mode_count = res_count_q;
	assign error      = res_error_q;

endmodule

// ===== test/rmq_checker.sv =====
`timescale 1ns / 100ps
// Scoreboard for range_mode_query_core: watches both transfer channels, keeps its own
// copy of the element store, predicts each query answer and compares it with the result.
// Depends on rmq_pkg for the opcode constants.
module rmq_checker #(
	parameter int DEPTH = 65536
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [1:0]  opcode,
	input  logic [15:0] value,
	input  logic [15:0] left_index,
	input  logic [15:0] right_index,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [15:0] mode_value,
	input  logic [16:0] mode_count,
	input  logic        error,
	output int          fail_count,
	output int          pending,
	output int          answers_checked
);
	import rmq_pkg::*;

	typedef struct packed {
		logic [15:0] mval;
		logic [16:0] mcnt;
		logic        err;
	} mode_answer_t;

	logic [15:0] elem_mem [DEPTH];
	int unsigned elem_total = 0;
	int unsigned tally [65536];
	mode_answer_t answer_q [$];

	function automatic mode_answer_t predict_mode(logic [15:0] a, logic [15:0] b);
		int unsigned lo, hi, i, best_cnt, c;
		logic [15:0] best_val, v;
		mode_answer_t res;
		lo = (a < b) ? a : b;
		hi = (a < b) ? b : a;
		if (elem_total == 0 || hi >= elem_total) begin
			res = '{mval: 16'd0, mcnt: 17'd0, err: 1'b1};
			return res;
		end
		best_val = '0;
		best_cnt = 0;
		for (i = lo; i <= hi; i++) begin
			v = elem_mem[i];
			tally[v]++;
			c = tally[v];
			if (c > best_cnt || (c == best_cnt && v < best_val)) begin
				best_cnt = c;
				best_val = v;
			end
		end
		for (i = lo; i <= hi; i++)
			tally[elem_mem[i]] = 0;
		res = '{mval: best_val, mcnt: 17'(best_cnt), err: 1'b0};
		return res;
	endfunction

	always @(posedge clk) begin : watch
		mode_answer_t got, want;
		if (!arst_n) begin
			fail_count = 0;
			pending = 0;
			answers_checked = 0;
		end else begin
			if (out_valid && out_ready) begin
				got = '{mval: mode_value, mcnt: mode_count, err: error};
				if (answer_q.size() == 0) begin
					$display("%0t: unexpected result, value %h count %0d error %b",
						$time, mode_value, mode_count, error);
					fail_count++;
				end else begin
					want = answer_q.pop_front();
					answers_checked++;
					if (got !== want) begin
						fail_count++;
						if (got.mval !== want.mval)
							$display("%0t: mode_value mismatch, expected %h, got %h",
								$time, want.mval, got.mval);
						if (got.mcnt !== want.mcnt)
							$display("%0t: mode_count mismatch, expected %0d, got %0d",
								$time, want.mcnt, got.mcnt);
						if (got.err !== want.err)
							$display("%0t: error mismatch, expected %b, got %b",
								$time, want.err, got.err);
					end
				end
			end
			if (in_valid && in_ready) begin
				case (opcode)
					OP_CLEAR: begin
						elem_total = 0;
					end
					OP_APPEND: begin
						if (elem_total < DEPTH) begin
							elem_mem[elem_total] = value;
							elem_total++;
						end
					end
					OP_QUERY: begin
						answer_q = {answer_q, predict_mode(left_index, right_index)};
					end
					default: begin
					end
				endcase
			end
			pending = answer_q.size();
		end
	end

endmodule

// ===== test/tb_range_mode_query_core.sv =====
`timescale 1ns / 100ps
// Top of the range_mode_query_core bench: clock, reset, transfer stimulus and verdict.
// Depends on rmq_pkg, range_mode_query_core and rmq_checker.
module tb_range_mode_query_core;
	import rmq_pkg::*;

	localparam int DEPTH = 65536;
	localparam int VALUE_WIDTH = 16;
	localparam int CYCLE_LIMIT = 4000000;
	localparam logic [1:0] OP_NOP = 2'd3;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [1:0]  opcode = OP_CLEAR;
	logic [15:0] value = '0;
	logic [15:0] left_index = '0;
	logic [15:0] right_index = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [15:0] mode_value;
	logic [16:0] mode_count;
	logic        error;
	int          fail_count, pending, answers_checked;
	int          cycles = 0;
	int          sent = 0;
	int          loaded = 0;
	bit          steady = 1'b0;

	always #5 clk = ~clk;

	range_mode_query_core #(
		.DEPTH(DEPTH),
		.VALUE_WIDTH(VALUE_WIDTH)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.opcode(opcode),
		.value(value),
		.left_index(left_index),
		.right_index(right_index),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.mode_value(mode_value),
		.mode_count(mode_count),
		.error(error)
	);

	rmq_checker #(
		.DEPTH(DEPTH)
	) mode_check (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.opcode(opcode),
		.value(value),
		.left_index(left_index),
		.right_index(right_index),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.mode_value(mode_value),
		.mode_count(mode_count),
		.error(error),
		.fail_count(fail_count),
		.pending(pending),
		.answers_checked(answers_checked)
	);

	always @(posedge clk) begin
		out_ready <= steady || ($urandom_range(99) >= 35);
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("range_mode_query_core verification failed");
			$finish;
		end
	end

	task automatic send_item(input logic [1:0] op, input logic [15:0] val,
		input logic [15:0] lidx, input logic [15:0] ridx);
		while (!steady && $urandom_range(99) < 35) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		opcode <= op;
		value <= val;
		left_index <= lidx;
		right_index <= ridx;
		do @(posedge clk); while (!in_ready);
		sent++;
		case (op)
			OP_CLEAR: begin
				loaded = 0;
			end
			OP_APPEND: begin
				if (loaded < DEPTH)
					loaded++;
			end
			default: begin
			end
		endcase
	endtask

	initial begin : stimulus
		int counted;
		int r;
		logic [15:0] a, b;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		send_item(OP_QUERY, 16'h0000, 16'h0000, 16'h0000);
		send_item(OP_APPEND, 16'h0000, 16'h0000, 16'h0000);
		send_item(OP_APPEND, 16'hFFFF, 16'h0000, 16'h0000);
		send_item(OP_APPEND, 16'hFFFF, 16'h0000, 16'h0000);
		send_item(OP_APPEND, 16'h0000, 16'h0000, 16'h0000);
		send_item(OP_APPEND, 16'h1234, 16'h0000, 16'h0000);
		send_item(OP_QUERY, 16'h0000, 16'h0000, 16'h0004);
		send_item(OP_QUERY, 16'h0000, 16'h0004, 16'h0001);
		send_item(OP_QUERY, 16'h0000, 16'h0002, 16'h0002);
		send_item(OP_QUERY, 16'h0000, 16'h0000, 16'h0005);
		send_item(OP_QUERY, 16'h0000, 16'hFFFF, 16'h0000);
		send_item(OP_QUERY, 16'h0000, 16'h0000, 16'hFFFF);
		send_item(OP_NOP, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		send_item(OP_CLEAR, 16'h0000, 16'h0000, 16'h0000);
		send_item(OP_QUERY, 16'h0000, 16'h0000, 16'h0000);
		send_item(OP_APPEND, 16'h8000, 16'h0000, 16'h0000);
		send_item(OP_APPEND, 16'h7FFF, 16'h0000, 16'h0000);
		send_item(OP_QUERY, 16'h0000, 16'h0001, 16'h0000);
		send_item(OP_QUERY, 16'h0000, 16'h0000, 16'h0002);
		send_item(OP_APPEND, 16'h7FFF, 16'h0000, 16'h0000);
		send_item(OP_QUERY, 16'h0000, 16'h0000, 16'h0002);

		counted = 0;
		while (counted < 100) begin
			steady = (counted >= 40 && counted < 70);
			r = $urandom_range(99);
			a = 16'($urandom());
			b = 16'($urandom());
			if (r < 4 || (r < 45 && loaded >= 64)) begin
				send_item(OP_CLEAR, a, b, a);
			end else if (r < 45) begin
				send_item(OP_APPEND,
					($urandom_range(99) < 60) ? 16'($urandom_range(5)) : a, a, b);
			end else if (r < 85 && loaded > 0) begin
				send_item(OP_QUERY, a, 16'($urandom_range(loaded - 1)),
					16'($urandom_range(loaded - 1)));
			end else if (r < 95) begin
				send_item(OP_QUERY, a, ($urandom_range(1) != 0) ? a : 16'(loaded), b);
			end else begin
				send_item(OP_NOP, a, b, a);
				counted--;
			end
			counted++;
		end

		steady = 1'b0;
		in_valid <= 1'b0;

		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		$display("Sent %0d input transfers and checked %0d query results.", sent, answers_checked);
		$display("Covered ties, reversed and out-of-range queries, clears and ignored opcodes.");
		if (fail_count == 0) begin
			$display("range_mode_query_core verification clean");
		end else begin
			$display("range_mode_query_core verification failed");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/rmq_pkg.sv
rtl/range_mode_query_core.sv
test/rmq_checker.sv
test/tb_range_mode_query_core.sv
